// ----- rtl/core/sisi_pkg.sv -----
// Shared types and constants for the sorted identifier set store.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package sisi_pkg;

	// Payload widths of the channels
	localparam int unsigned ID_W    = 32;
	localparam int unsigned POS_W   = 10;
	localparam int unsigned COUNT_W = 11;

	// Default number of cells
	localparam int unsigned DEPTH_DEF = 1024;

	// Reduction tree: fan-in per registered level
	localparam int unsigned GROUP_LG = 5;
	localparam int unsigned GROUP    = 1 << GROUP_LG;

	// Leaf of the reduction: match flag over read data
	localparam int unsigned LEAF_W = ID_W + 1;

	typedef enum logic [1:0] {
		MODE_INSERT   = 2'd0,
		MODE_REMOVE   = 2'd1,
		MODE_CONTAINS = 2'd2,
		MODE_READ     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_RED,
		ST_APPLY
	} state_t;

	// Per-cycle command to every cell
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctrl_t;

	// Number of registered levels in a tree of GROUP-input OR nodes over n leaves
	function automatic int unsigned tree_levels(input int unsigned n);
		int unsigned m;
		int unsigned lv;
		m  = n;
		lv = 0;
		for (int i = 0; i < 8; i++) begin
			if (m > 1 || lv == 0) begin
				m  = (m + GROUP - 1) >> GROUP_LG;
				lv = lv + 1;
			end
		end
		return lv;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sisi_if.sv -----
// Valid/ready channel interfaces for command and response beats.
// Depends on sisi_pkg for payload widths and codes.
`default_nettype none

interface sisi_cmd_if;
	logic                      valid;
	logic                      ready;
	sisi_pkg::mode_t           mode;
	logic [sisi_pkg::ID_W-1:0]  doc_id;
	logic [sisi_pkg::POS_W-1:0] position;

	modport source (output valid, mode, doc_id, position, input ready);
	modport sink   (input valid, mode, doc_id, position, output ready);
endinterface

interface sisi_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        found;
	logic [sisi_pkg::ID_W-1:0]    value;
	logic [sisi_pkg::COUNT_W-1:0] entry_count;
	sisi_pkg::status_t           status;

	modport source (output valid, found, value, entry_count, status, input ready);
	modport sink   (input valid, found, value, entry_count, status, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sisi_cell.sv -----
// One cell of the sorted chain: holds one identifier and its valid bit,
// compares against the broadcast key and shifts with its neighbors. Uses sisi_pkg.
`default_nettype none

module sisi_cell #(
	parameter int unsigned INDEX = 0,
	parameter int unsigned PW    = sisi_pkg::POS_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sisi_pkg::ID_W-1:0]     id,
	input  logic [PW-1:0]                 pos,
	input  logic                          rd,
	input  sisi_pkg::cell_ctrl_t          ctrl,
	input  logic [sisi_pkg::ID_W-1:0]     prev_value,
	input  logic                          prev_valid,
	input  logic                          prev_lt,
	input  logic [sisi_pkg::ID_W-1:0]     next_value,
	input  logic                          next_valid,
	output logic [sisi_pkg::ID_W-1:0]     value,
	output logic                          valid,
	output logic                          lt,
	output logic [sisi_pkg::LEAF_W-1:0]   leaf
);

	logic [sisi_pkg::ID_W-1:0]   value_q;
	logic                        valid_q;
	logic                        lt_s1;
	logic [sisi_pkg::LEAF_W-1:0] leaf_s1;
	logic                        sel;

	assign sel = rd && valid_q && (pos == PW'(INDEX));

	// Compare stage: below-key flag and reduction leaf
	always_ff @(posedge clk) begin
		lt_s1   <= valid_q && (value_q < id);
		leaf_s1 <= {valid_q && (value_q == id), sel ? value_q : '0};
	end

	// Shift the stored identifier: up on insert, down on remove
	always_ff @(posedge clk) begin
		if (ctrl.ins && !lt_s1) begin
			value_q <= prev_lt ? id : prev_value;
		end else if (ctrl.del && !lt_s1) begin
			value_q <= next_value;
		end
	end

	// Track occupancy along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins) begin
			valid_q <= valid_q | prev_valid;
		end else if (ctrl.del) begin
			valid_q <= next_valid;
		end
	end

	assign value = value_q;
	assign valid = valid_q;
	assign lt    = lt_s1;
	assign leaf  = leaf_s1;

endmodule

`default_nettype wire

// ----- rtl/core/sisi_or_tree.sv -----
// Registered OR reduction tree, GROUP inputs per node and one register per level;
// recurses until one node is left. Uses sisi_pkg for the fan-in.
`default_nettype none

module sisi_or_tree #(
	parameter int unsigned N = sisi_pkg::GROUP,
	parameter int unsigned W = sisi_pkg::LEAF_W
) (
	input  logic         clk,
	input  logic [W-1:0] leaf [N],
	output logic [W-1:0] root
);

	localparam int unsigned M = (N + sisi_pkg::GROUP - 1) >> sisi_pkg::GROUP_LG;

	logic [W-1:0] part   [M][sisi_pkg::GROUP];
	logic [W-1:0] grp_s1 [M];

	// Gather leaves into groups, padding the last one with zeros
	for (genvar g = 0; g < M; g++) begin : g_grp
		for (genvar j = 0; j < sisi_pkg::GROUP; j++) begin : g_in
			if (g * sisi_pkg::GROUP + j < N) begin : g_used
				assign part[g][j] = leaf[g * sisi_pkg::GROUP + j];
			end else begin : g_pad
				assign part[g][j] = '0;
			end
		end

		// Reduce one group and register it
		always_ff @(posedge clk) begin
			logic [W-1:0] acc;
			acc = '0;
			for (int k = 0; k < sisi_pkg::GROUP; k++) begin
				acc = acc | part[g][k];
			end
			grp_s1[g] <= acc;
		end
	end

	if (M > 1) begin : g_sub
		sisi_or_tree #(
			.N(M),
			.W(W)
		) u_sub (
			.clk (clk),
			.leaf(grp_s1),
			.root(root)
		);
	end else begin : g_top
		assign root = grp_s1[0];
	end

endmodule

`default_nettype wire

// ----- rtl/core/sorted_id_set_store.sv -----
// Sorted identifier set store: a chain of DEPTH cells, one identifier each.
// A command beat is captured, compared in the cells, reduced through L = ceil(log32(DEPTH))
// registered OR-tree levels (L = 2 for DEPTH 1024) and applied; the response is registered.
// One command at a time: a new one is accepted only in the idle state, after the compare
// stage, the reduction tree and the apply step, which waits for a free response slot.
// Reset: arst_n empties the store (all cells invalid, count zero); no clearing pass.
`default_nettype none

module sorted_id_set_store #(
	parameter int unsigned DEPTH = sisi_pkg::DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	sisi_cmd_if.sink        cmd,
	sisi_rsp_if.source      rsp
);

	localparam int unsigned FILL_W = $clog2(DEPTH + 1);
	localparam int unsigned IDX_W  = $clog2(DEPTH);
	localparam int unsigned PW     = (IDX_W > sisi_pkg::POS_W) ? IDX_W : sisi_pkg::POS_W;
	localparam int unsigned CW     = (FILL_W > sisi_pkg::POS_W) ? FILL_W : sisi_pkg::POS_W;
	localparam int unsigned LEVELS = sisi_pkg::tree_levels(DEPTH);
	localparam int unsigned CNT_W  = $clog2(LEVELS + 1);

	sisi_pkg::state_t             state_q, state_nxt;
	logic [CNT_W-1:0]             cnt_q;
	sisi_pkg::mode_t              mode_q;
	logic [sisi_pkg::ID_W-1:0]    id_q;
	logic [sisi_pkg::POS_W-1:0]   pos_q;
	logic [FILL_W-1:0]            fill_q, fill_nxt;

	logic                         rsp_valid_q;
	logic                         found_q;
	logic [sisi_pkg::ID_W-1:0]    value_q;
	logic [sisi_pkg::COUNT_W-1:0] count_q;
	sisi_pkg::status_t            status_q;

	sisi_pkg::cell_ctrl_t         ctrl;
	logic                         accept;
	logic                         commit;
	logic                         slot_free;
	logic                         present;
	logic                         full;
	logic                         pos_ok;
	logic                         rd;
	logic                         rsp_found;
	sisi_pkg::status_t            rsp_status;

	logic [sisi_pkg::ID_W-1:0]    cell_value [DEPTH];
	logic                         cell_valid [DEPTH];
	logic                         cell_lt    [DEPTH];
	logic [sisi_pkg::LEAF_W-1:0]  leaf       [DEPTH];
	logic [sisi_pkg::LEAF_W-1:0]  root;

	assign accept    = cmd.valid && cmd.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign rd        = (mode_q == sisi_pkg::MODE_READ);
	assign present   = root[sisi_pkg::ID_W];
	assign full      = (fill_q == FILL_W'(DEPTH));
	assign pos_ok    = CW'(pos_q) < CW'(fill_q);

	// Capture the command beat
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= cmd.mode;
			id_q   <= cmd.doc_id;
			pos_q  <= cmd.position;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sisi_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					state_nxt = sisi_pkg::ST_CMP;
				end
			end
			sisi_pkg::ST_CMP: begin
				state_nxt = sisi_pkg::ST_RED;
			end
			sisi_pkg::ST_RED: begin
				if (cnt_q == CNT_W'(LEVELS - 1)) begin
					state_nxt = sisi_pkg::ST_APPLY;
				end
			end
			sisi_pkg::ST_APPLY: begin
				if (slot_free) begin
					state_nxt = sisi_pkg::ST_IDLE;
				end
			end
			default: state_nxt = sisi_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		cmd.ready = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			sisi_pkg::ST_IDLE:  cmd.ready = 1'b1;
			sisi_pkg::ST_APPLY: commit    = slot_free;
			default: begin
				cmd.ready = 1'b0;
				commit    = 1'b0;
			end
		endcase
		ctrl.ins = commit && (mode_q == sisi_pkg::MODE_INSERT) && !present && !full;
		ctrl.del = commit && (mode_q == sisi_pkg::MODE_REMOVE) && present;
	end

	// Advance state and the tree-level counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sisi_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == sisi_pkg::ST_RED) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// Fill count after this command
	always_comb begin
		fill_nxt = fill_q;
		if (ctrl.ins) begin
			fill_nxt = fill_q + FILL_W'(1);
		end else if (ctrl.del) begin
			fill_nxt = fill_q - FILL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_nxt;
		end
	end

	// Response fields
	always_comb begin
		rsp_found  = rd ? pos_ok : present;
		rsp_status = sisi_pkg::STATUS_OK;
		if (rd && !pos_ok) begin
			rsp_status = sisi_pkg::STATUS_RANGE;
		end else if ((mode_q == sisi_pkg::MODE_INSERT) && !present && full) begin
			rsp_status = sisi_pkg::STATUS_FULL;
		end
	end

	// Hold the response beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			found_q  <= rsp_found;
			value_q  <= root[sisi_pkg::ID_W-1:0];
			count_q  <= sisi_pkg::COUNT_W'(fill_nxt);
			status_q <= rsp_status;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = found_q;
	assign rsp.value       = value_q;
	assign rsp.entry_count = count_q;
	assign rsp.status      = status_q;

	// Chain of cells
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [sisi_pkg::ID_W-1:0] pv;
		logic                      pvl;
		logic                      plt;
		logic [sisi_pkg::ID_W-1:0] nv;
		logic                      nvl;

		if (k == 0) begin : g_head
			assign pv  = '0;
			assign pvl = 1'b1;
			assign plt = 1'b1;
		end else begin : g_mid
			assign pv  = cell_value[k-1];
			assign pvl = cell_valid[k-1];
			assign plt = cell_lt[k-1];
		end

		if (k == DEPTH - 1) begin : g_tail
			assign nv  = '0;
			assign nvl = 1'b0;
		end else begin : g_body
			assign nv  = cell_value[k+1];
			assign nvl = cell_valid[k+1];
		end

		sisi_cell #(
			.INDEX(k),
			.PW   (PW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.id        (id_q),
			.pos       (PW'(pos_q)),
			.rd        (rd),
			.ctrl      (ctrl),
			.prev_value(pv),
			.prev_valid(pvl),
			.prev_lt   (plt),
			.next_value(nv),
			.next_valid(nvl),
			.value     (cell_value[k]),
			.valid     (cell_valid[k]),
			.lt        (cell_lt[k]),
			.leaf      (leaf[k])
		);
	end

	// Presence flag and read data gathered over all cells
	sisi_or_tree #(
		.N(DEPTH),
		.W(sisi_pkg::LEAF_W)
	) u_tree (
		.clk (clk),
		.leaf(leaf),
		.root(root)
	);

endmodule

`default_nettype wire
